@@ hdl/lmst_pkg.sv @@
// ============================================================================
// Longest-match sign tokenizer: shared package
// Holds the default sizes, token kind codes, register indexes and the types
// of the configuration and of the front-end status seen by the top level.
// ============================================================================
package lmst_pkg;

    localparam int DEF_NUM_SIGNS    = 8;
    localparam int DEF_MAX_SIGN_LEN = 4;
    localparam int DEF_POS_WIDTH    = 16;
    localparam int DEF_NUM_IGNORE   = 8;

    // Depth of the queue between the front end and the back end.
    localparam int QUEUE_DEPTH = 4;

    localparam logic [3:0] KIND_IDENT  = 4'd8;
    localparam logic [3:0] KIND_MARKER = 4'd9;

    // Register indexes on the configuration port (address bits [5:3]).
    localparam logic [2:0] REG_SIGN_A  = 3'd0;
    localparam logic [2:0] REG_SIGN_B  = 3'd1;
    localparam logic [2:0] REG_SIGN_C  = 3'd2;
    localparam logic [2:0] REG_SIGN_D  = 3'd3;
    localparam logic [2:0] REG_SIGN_LEN = 3'd4;
    localparam logic [2:0] REG_IGN_CHR = 3'd5;
    localparam logic [2:0] REG_IGN_CNT = 3'd6;

    typedef struct packed {
        logic [3:0][63:0] sign_chars;
        logic [23:0]      sign_lengths;
        logic [63:0]      ignore_chars;
        logic [3:0]       ignore_count;
    } t_cfg;

    // Status of the front end, seen by the top level.
    typedef struct packed {
        logic drain;
        logic pend;
        logic push;
        logic room;
    } t_fstat;

endpackage

@@ hdl/longest_match_sign_tokenizer_unit.sv @@
// ============================================================================
// Longest-match sign tokenizer
// Splits a byte stream into sign tokens and identifiers by longest match.
// ============================================================================
// Source text enters one byte per transfer and the block sustains one byte
// per clock while the input is not stalled: a byte is taken every cycle
// while the lookahead window fills, and once it is full each new byte is
// taken in the same cycle as the oldest byte is decided, with all sign
// compares done in parallel over the window. The byte that ends a source
// starts a flush that decides each byte still in the window (up to the
// window depth), then hands over the final entry; input stalls meanwhile.
// Queued results leave one per unstalled cycle through an output register, so
// a stalled output side only holds the input once the queue is full.  Each
// token gives its kind (sign index, identifier or end marker), its start and
// end positions, a saturation flag and a flag on the last result of a source.
// Configuration registers sit at byte address 8*i on the 64-bit register
// port and must only be written while the block is idle.
module longest_match_sign_tokenizer_unit #(
    parameter int NUM_SIGNS    = lmst_pkg::DEF_NUM_SIGNS,
    parameter int MAX_SIGN_LEN = lmst_pkg::DEF_MAX_SIGN_LEN,
    parameter int POS_WIDTH    = lmst_pkg::DEF_POS_WIDTH,
    parameter int NUM_IGNORE   = lmst_pkg::DEF_NUM_IGNORE
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [5:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready,
    // source byte channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_char_in,
    input  logic                 i_end_of_source,
    // token channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [3:0]           o_token_kind,
    output logic [POS_WIDTH-1:0] o_start_pos,
    output logic [POS_WIDTH-1:0] o_end_pos,
    output logic                 o_pos_overflow,
    output logic                 o_last_token
);

    localparam int RW = 6 + 2 * POS_WIDTH;
    localparam int EW = 1 + 2 * RW;

    lmst_pkg::t_cfg   r_cfg;
    lmst_pkg::t_fstat fstat;
    logic             wr_en;
    logic [2:0]       reg_idx;
    logic             push, room, pop, nempty;
    logic [EW-1:0]    entry, head;

    // The register port never waits.
    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                lmst_pkg::REG_SIGN_A:   r_cfg.sign_chars[0] <= pwdata;
                lmst_pkg::REG_SIGN_B:   r_cfg.sign_chars[1] <= pwdata;
                lmst_pkg::REG_SIGN_C:   r_cfg.sign_chars[2] <= pwdata;
                lmst_pkg::REG_SIGN_D:   r_cfg.sign_chars[3] <= pwdata;
                lmst_pkg::REG_SIGN_LEN: r_cfg.sign_lengths  <= pwdata[23:0];
                lmst_pkg::REG_IGN_CHR:  r_cfg.ignore_chars  <= pwdata;
                lmst_pkg::REG_IGN_CNT:  r_cfg.ignore_count  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            lmst_pkg::REG_SIGN_A:   prdata = r_cfg.sign_chars[0];
            lmst_pkg::REG_SIGN_B:   prdata = r_cfg.sign_chars[1];
            lmst_pkg::REG_SIGN_C:   prdata = r_cfg.sign_chars[2];
            lmst_pkg::REG_SIGN_D:   prdata = r_cfg.sign_chars[3];
            lmst_pkg::REG_SIGN_LEN: prdata = {40'd0, r_cfg.sign_lengths};
            lmst_pkg::REG_IGN_CHR:  prdata = r_cfg.ignore_chars;
            lmst_pkg::REG_IGN_CNT:  prdata = {60'd0, r_cfg.ignore_count};
            default:                prdata = '0;
        endcase
    end

    // The front end owns the window and all position bookkeeping.
    lmst_front #(
        .NUM_SIGNS(NUM_SIGNS), .MAX_SIGN_LEN(MAX_SIGN_LEN),
        .POS_WIDTH(POS_WIDTH), .NUM_IGNORE(NUM_IGNORE), .RW(RW), .EW(EW)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(i_in_valid), .i_char(i_char_in), .i_eos(i_end_of_source),
        .o_stall(o_in_stall), .o_push(push), .o_entry(entry),
        .i_room(room), .o_stat(fstat)
    );

    // Entries of one or two results wait here for the back end.
    lmst_fifo #(.W(EW), .DEPTH(lmst_pkg::QUEUE_DEPTH)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(entry),
        .o_room(room), .i_pop(pop), .o_nempty(nempty), .o_head(head)
    );

    lmst_back #(.POS_WIDTH(POS_WIDTH), .RW(RW), .EW(EW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_nempty(nempty), .i_head(head),
        .o_pop(pop), .o_valid(o_out_valid), .i_stall(i_out_stall),
        .o_kind(o_token_kind), .o_start(o_start_pos), .o_end(o_end_pos),
        .o_ovf(o_pos_overflow), .o_last(o_last_token)
    );

    // An entry is only ever pushed when the queue has room for it.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fstat.push |-> fstat.room)
        else $error("entry pushed into a full queue");

    // While a source is being flushed no new byte may be taken.
    a_drain_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fstat.drain || fstat.pend) |-> o_in_stall)
        else $error("byte taken while flushing a source");

    // An end marker is always the final result of its source.
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_token_kind == lmst_pkg::KIND_MARKER) |-> o_last_token)
        else $error("end marker without last flag");

endmodule

@@ hdl/lmst_fifo.sv @@
// ============================================================================
// Longest-match sign tokenizer: entry queue
// A small first-in first-out queue of token entries between the two halves.
// ============================================================================
module lmst_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = lmst_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_room,
    input  logic         i_pop,
    output logic         o_nempty,
    output logic [W-1:0] o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_room   = r_cnt != CW'(DEPTH);
    assign o_nempty = r_cnt != '0;
    assign o_head   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

endmodule

@@ hdl/lmst_front.sv @@
// ============================================================================
// Longest-match sign tokenizer: front end
// Takes source bytes into the lookahead window, decides the oldest byte
// and builds queue entries of one or two token results.
// ============================================================================
module lmst_front #(
    parameter int NUM_SIGNS    = lmst_pkg::DEF_NUM_SIGNS,
    parameter int MAX_SIGN_LEN = lmst_pkg::DEF_MAX_SIGN_LEN,
    parameter int POS_WIDTH    = lmst_pkg::DEF_POS_WIDTH,
    parameter int NUM_IGNORE   = lmst_pkg::DEF_NUM_IGNORE,
    parameter int RW           = 6 + 2 * POS_WIDTH,
    parameter int EW           = 1 + 2 * RW
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lmst_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    input  logic [7:0]      i_char,
    input  logic            i_eos,
    output logic            o_stall,
    output logic            o_push,
    output logic [EW-1:0]   o_entry,
    input  logic            i_room,
    output lmst_pkg::t_fstat o_stat
);

    localparam int FW  = $clog2(MAX_SIGN_LEN + 1);
    localparam int CMP = (MAX_SIGN_LEN < 4) ? MAX_SIGN_LEN : 4;
    localparam int IGL = (NUM_IGNORE < 8) ? NUM_IGNORE : 8;
    localparam logic [POS_WIDTH-1:0] PMAX = {POS_WIDTH{1'b1}};

    logic [7:0]           r_win [MAX_SIGN_LEN];
    logic [FW-1:0]        r_fill, n_fill;
    logic [POS_WIDTH-1:0] r_pos, n_pos, r_ident, n_ident;
    logic [FW-1:0]        r_skip, n_skip;
    logic                 r_ovf, n_ovf, r_drain, n_drain, r_pv, n_pv;
    logic [EW-1:0]        r_pend, n_pend;

    function automatic logic [RW-1:0] pack_res(input logic [3:0] kind,
        input logic [POS_WIDTH-1:0] s, input logic [POS_WIDTH-1:0] e,
        input logic ovf);
        pack_res = {1'b0, ovf, e, s, kind};
    endfunction

    // Flags the final result of an entry as the last of its source.
    function automatic logic [EW-1:0] mark_last(input logic [EW-1:0] ent);
        logic [EW-1:0] m;
        m = ent;
        if (ent[EW-1]) begin
            m[2*RW-1] = 1'b1;
        end else begin
            m[RW-1] = 1'b1;
        end
        mark_last = m;
    endfunction

    logic                 ign, found, hit, full, go_dec, accept, fin;
    logic [3:0]           ign_n;
    logic [2:0]           blen, slen, which;
    logic [POS_WIDTH:0]   sum_e, sum_1;
    logic [POS_WIDTH-1:0] e_pos, p1_pos;
    logic [RW-1:0]        res0, res1;
    logic                 v0, v1, e_ovf;
    logic [EW-1:0]        ent_new;

    // Classification of the oldest window byte.
    always_comb begin
        ign_n = (i_cfg.ignore_count > 4'(IGL)) ? 4'(IGL) : i_cfg.ignore_count;
        ign = 1'b0;
        for (int k = 0; k < 8; k++) begin
            if (4'(k) < ign_n && r_win[0] == i_cfg.ignore_chars[8*k +: 8]) begin
                ign = 1'b1;
            end
        end
        found = 1'b0;
        blen  = '0;
        which = '0;
        for (int i = 0; i < 8; i++) begin
            slen = i_cfg.sign_lengths[3*i +: 3];
            hit = (i < NUM_SIGNS) && (slen != 3'd0) && (slen <= 3'(CMP))
                && ({1'b0, slen} <= 4'(r_fill)) && (slen > blen);
            for (int j = 0; j < CMP; j++) begin
                if (3'(j) < slen
                    && r_win[j] != i_cfg.sign_chars[i/2][32*(i%2) + 8*j +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                found = 1'b1;
                blen  = slen;
                which = 3'(i);
            end
        end
    end

    // Effect of deciding the oldest byte, with the end-of-source close.
    always_comb begin
        sum_e  = {1'b0, r_pos} + (POS_WIDTH + 1)'(blen);
        sum_1  = {1'b0, r_pos} + (POS_WIDTH + 1)'(1);
        e_pos  = sum_e[POS_WIDTH] ? PMAX : sum_e[POS_WIDTH-1:0];
        p1_pos = sum_1[POS_WIDTH] ? PMAX : sum_1[POS_WIDTH-1:0];
        e_ovf  = r_ovf | sum_e[POS_WIDTH];
        n_ident = r_ident;
        n_skip  = r_skip;
        n_ovf   = r_ovf;
        res0 = '0;
        res1 = '0;
        v0 = 1'b0;
        v1 = 1'b0;
        if (r_skip != '0) begin
            n_skip = r_skip - FW'(1);
        end else if (ign) begin
            if (r_pos > r_ident) begin
                res0 = pack_res(lmst_pkg::KIND_IDENT, r_ident, r_pos, r_ovf);
                v0 = 1'b1;
            end
            n_ident = p1_pos;
            n_ovf   = r_ovf | sum_1[POS_WIDTH];
        end else if (found) begin
            n_ovf = e_ovf;
            if (r_pos > r_ident) begin
                res0 = pack_res(lmst_pkg::KIND_IDENT, r_ident, r_pos, e_ovf);
                res1 = pack_res({1'b0, which}, r_pos, e_pos, e_ovf);
                v0 = 1'b1;
                v1 = 1'b1;
            end else begin
                res0 = pack_res({1'b0, which}, r_pos, e_pos, e_ovf);
                v0 = 1'b1;
            end
            n_skip  = FW'(blen - 3'd1);
            n_ident = e_pos;
        end
        if (r_pos == PMAX) begin
            n_pos = PMAX;
            n_ovf = 1'b1;
        end else begin
            n_pos = r_pos + POS_WIDTH'(1);
        end
        fin = r_drain && r_fill == FW'(1);
        if (fin && n_pos > n_ident) begin
            if (!v0) begin
                res0 = pack_res(lmst_pkg::KIND_IDENT, n_ident, n_pos, n_ovf);
                v0 = 1'b1;
            end else begin
                res1 = pack_res(lmst_pkg::KIND_IDENT, n_ident, n_pos, n_ovf);
                v1 = 1'b1;
            end
        end
        ent_new = {v1, res1, res0};
    end

    // Handshake, queue push and the held entry of a draining source.
    always_comb begin
        full    = r_fill == FW'(MAX_SIGN_LEN);
        go_dec  = i_room && (r_drain || (full && !r_pv));
        accept  = i_valid && !r_drain && !r_pv && (!full || go_dec);
        o_stall = r_drain || r_pv || (full && !i_room);
        o_push  = 1'b0;
        o_entry = ent_new;
        n_pend  = r_pend;
        n_pv    = r_pv;
        if (go_dec && !r_drain) begin
            o_push = v0;
        end else if (go_dec && !fin) begin
            if (v0) begin
                o_push  = r_pv;
                o_entry = r_pend;
                n_pend  = ent_new;
                n_pv    = 1'b1;
            end
        end else if (go_dec) begin
            if (v0 && r_pv) begin
                o_push  = 1'b1;
                o_entry = r_pend;
                n_pend  = mark_last(ent_new);
            end else if (v0) begin
                o_push  = 1'b1;
                o_entry = mark_last(ent_new);
            end else if (r_pv) begin
                o_push  = 1'b1;
                o_entry = mark_last(r_pend);
                n_pv    = 1'b0;
            end else begin
                o_push  = 1'b1;
                o_entry = {1'b0, RW'(0),
                    1'b1, n_ovf, n_pos, n_pos, lmst_pkg::KIND_MARKER};
            end
        end else if (r_pv && i_room) begin
            o_push  = 1'b1;
            o_entry = r_pend;
            n_pv    = 1'b0;
        end
        n_fill  = r_fill - FW'(go_dec) + FW'(accept);
        n_drain = r_drain ? !(go_dec && fin) : (accept && i_eos);
    end

    assign o_stat = '{drain: r_drain, pend: r_pv, push: o_push, room: i_room};

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_SIGN_LEN; k++) begin
            if (accept && FW'(k) == (go_dec ? r_fill - FW'(1) : r_fill)) begin
                r_win[k] <= i_char;
            end else if (go_dec) begin
                r_win[k] <= r_win[(k < MAX_SIGN_LEN - 1) ? k + 1 : k];
            end
        end
        r_pend <= n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_pos   <= '0;
            r_ident <= '0;
            r_skip  <= '0;
            r_ovf   <= 1'b0;
            r_drain <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_drain <= n_drain;
            r_pv    <= n_pv;
            if (go_dec && fin) begin
                r_fill  <= '0;
                r_pos   <= '0;
                r_ident <= '0;
                r_skip  <= '0;
                r_ovf   <= 1'b0;
            end else if (go_dec) begin
                r_pos   <= n_pos;
                r_ident <= n_ident;
                r_skip  <= n_skip;
                r_ovf   <= n_ovf;
            end
        end
    end

endmodule

@@ hdl/lmst_back.sv @@
// ============================================================================
// Longest-match sign tokenizer: back end
// Takes entries from the queue and hands out their results one at a time
// from an output register.
// ============================================================================
module lmst_back #(
    parameter int POS_WIDTH = lmst_pkg::DEF_POS_WIDTH,
    parameter int RW        = 6 + 2 * POS_WIDTH,
    parameter int EW        = 1 + 2 * RW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_nempty,
    input  logic [EW-1:0]        i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [3:0]           o_kind,
    output logic [POS_WIDTH-1:0] o_start,
    output logic [POS_WIDTH-1:0] o_end,
    output logic                 o_ovf,
    output logic                 o_last
);

    logic          r_bv, r_idx;
    logic [EW-1:0] r_ent;
    logic [RW-1:0] sel;
    logic          take, done;

    assign sel   = r_idx ? r_ent[2*RW-1:RW] : r_ent[RW-1:0];
    assign take  = r_bv && !i_stall;
    assign done  = !r_bv || (take && (r_idx || !r_ent[EW-1]));
    assign o_pop = done && i_nempty;

    assign o_valid = r_bv;
    assign o_kind  = sel[3:0];
    assign o_start = sel[4 +: POS_WIDTH];
    assign o_end   = sel[4 + POS_WIDTH +: POS_WIDTH];
    assign o_ovf   = sel[RW-2];
    assign o_last  = sel[RW-1];

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv  <= 1'b0;
            r_idx <= 1'b0;
        end else if (take && !r_idx && r_ent[EW-1]) begin
            r_idx <= 1'b1;
        end else if (done) begin
            r_bv  <= i_nempty;
            r_idx <= 1'b0;
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Testbench for the longest-match sign tokenizer
// Feeds source text through the byte channel and checks every token against
// a bench predictor or a token typed into the table. It runs a directed table
// first, then random sources under several sign sets and register extremes.
// ============================================================================
module testbench;

    localparam int POS_MAX    = 65535;
    localparam int QUIET_MAX  = 2000;
    localparam int SETTLE     = 20;
    localparam int LONG_HOLD  = 300;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] first;
        logic [15:0] past;
        logic        ovf;
        logic        last;
    } t_token;

    typedef enum logic [1:0] {ROW_CFG, ROW_BYTE, ROW_TYPED} t_row_kind;

    typedef struct packed {
        t_row_kind   what;
        logic [2:0]  idx;
        logic [63:0] data;
        logic [7:0]  ch;
        logic        eos;
        t_token      tok;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite, pready;
    logic [5:0]  paddr;
    logic [63:0] pwdata, prdata;
    logic        i_in_valid, o_in_stall;
    logic [7:0]  i_char_in;
    logic        i_end_of_source;
    logic        o_out_valid, i_out_stall;
    logic [3:0]  o_token_kind;
    logic [15:0] o_start_pos, o_end_pos;
    logic        o_pos_overflow, o_last_token;

    longest_match_sign_tokenizer_unit dut (.*);

    // Register copies used by the predictor.
    logic [63:0] sign_regs [4];
    logic [23:0] len_reg;
    logic [63:0] ign_reg;
    logic [3:0]  ign_cnt_reg;

    // Predictor state.
    logic [7:0] window [4];
    int         fill, cur_pos, id_start, skip_left;
    bit         ovf_seen;

    t_token step_tokens[$];
    t_token pending_tokens[$];
    int     mismatches;
    bit     no_idle, hold_req, out_taken, in_seen, out_seen;
    int     stall_left;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [7:0] sign_byte(int i, int j);
        return sign_regs[i >> 1][(i & 1) * 32 + j * 8 +: 8];
    endfunction

    // Lengths above the window depth mark the sign as unused.
    function automatic int sign_len(int i);
        int l;
        l = len_reg[3 * i +: 3];
        return (l > 4) ? 0 : l;
    endfunction

    function automatic bit is_sep(logic [7:0] c);
        int n;
        n = (ign_cnt_reg > 8) ? 8 : ign_cnt_reg;
        for (int i = 0; i < n; i++)
            if (ign_reg[8 * i +: 8] == c) return 1'b1;
        return 1'b0;
    endfunction

    function automatic int clamp_pos(int v);
        if (v > POS_MAX) begin
            ovf_seen = 1'b1;
            return POS_MAX;
        end
        return v;
    endfunction

    function automatic void add_token(logic [3:0] k, int s, int e);
        t_token t;
        if (step_tokens.size() >= 5) return;
        t.kind  = k;
        t.first = s[15:0];
        t.past  = e[15:0];
        t.ovf   = ovf_seen;
        t.last  = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void clear_source();
        fill = 0; cur_pos = 0; id_start = 0; skip_left = 0; ovf_seen = 1'b0;
    endfunction

    function automatic void decide_front();
        int best, which, ln, e;
        best = 0;
        which = 0;
        if (skip_left > 0) begin
            skip_left--;
        end else if (is_sep(window[0])) begin
            if (cur_pos > id_start) add_token(lmst_pkg::KIND_IDENT, id_start, cur_pos);
            id_start = clamp_pos(cur_pos + 1);
        end else begin
            // Longest sign that fits wins; a tie keeps the lower index.
            for (int i = 0; i < 8; i++) begin
                bit ok;
                ln = sign_len(i);
                ok = (ln != 0) && (ln > best) && (ln <= fill);
                for (int j = 0; j < 4; j++)
                    if (ok && j < ln && window[j] != sign_byte(i, j)) ok = 1'b0;
                if (ok) begin
                    best = ln;
                    which = i;
                end
            end
            if (best > 0) begin
                e = clamp_pos(cur_pos + best);
                if (cur_pos > id_start) add_token(lmst_pkg::KIND_IDENT, id_start, cur_pos);
                add_token(which[3:0], cur_pos, e);
                skip_left = best - 1;
                id_start = e;
            end
        end
        for (int j = 0; j < 3; j++) window[j] = window[j + 1];
        fill--;
        if (cur_pos >= POS_MAX) begin
            cur_pos = POS_MAX;
            ovf_seen = 1'b1;
        end else begin
            cur_pos++;
        end
    endfunction

    // Works out the tokens caused by one accepted byte into step_tokens.
    function automatic void tokenize_byte(logic [7:0] c, logic eos);
        step_tokens.delete();
        if (fill < 4) begin
            window[fill] = c;
            fill++;
        end
        while (fill > 0 && (eos || fill >= 4)) decide_front();
        if (eos) begin
            if (cur_pos > id_start) add_token(lmst_pkg::KIND_IDENT, id_start, cur_pos);
            if (step_tokens.size() == 0)
                add_token(lmst_pkg::KIND_MARKER, cur_pos, cur_pos);
            step_tokens[step_tokens.size() - 1].last = 1'b1;
            clear_source();
        end
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic reg_write(logic [2:0] idx, logic [63:0] v);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            lmst_pkg::REG_SIGN_A, lmst_pkg::REG_SIGN_B,
            lmst_pkg::REG_SIGN_C, lmst_pkg::REG_SIGN_D: sign_regs[idx[1:0]] = v;
            lmst_pkg::REG_SIGN_LEN: len_reg = v[23:0];
            lmst_pkg::REG_IGN_CHR:  ign_reg = v;
            lmst_pkg::REG_IGN_CNT:  ign_cnt_reg = v[3:0];
            default: ;
        endcase
    endtask

    // Offers one byte; on its transfer the expected tokens are queued, either
    // from the predictor or the single token typed into the table.
    task automatic send_byte(logic [7:0] c, logic eos, bit typed, t_token tok);
        int  gap;
        bit  st;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_char_in <= c;
        i_end_of_source <= eos;
        do begin
            @(negedge i_clk);
            st = o_in_stall;
            @(posedge i_clk);
        end while (st);
        tokenize_byte(c, eos);
        if (typed) pending_tokens.push_back(tok);
        else foreach (step_tokens[k]) pending_tokens.push_back(step_tokens[k]);
    endtask

    // Lowers valid and waits until every expected token has come, then lets
    // the block settle so that no late work overlaps a register write.
    task automatic drain_all();
        i_in_valid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte(bit noise);
        int r;
        byte alpha [5] = '{8'h2B, 8'h2D, 8'h3D, 8'h3C, 8'h3E};
        r = $urandom_range(0, 99);
        if (noise || r < 10) return 8'($urandom_range(0, 255));
        if (r < 60) return alpha[$urandom_range(0, 4)];
        if (r < 80) return ign_reg[8 * $urandom_range(0, 7) +: 8];
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    function automatic logic [7:0] pick_sign_byte();
        byte alpha [5] = '{8'h2B, 8'h2D, 8'h3D, 8'h3C, 8'h3E};
        return alpha[$urandom_range(0, 4)];
    endfunction

    // One random sign and separator set; lengths now and then go above the window depth.
    task automatic random_config();
        logic [63:0] v;
        logic [23:0] l;
        logic [63:0] ig;
        for (int r = 0; r < 4; r++) begin
            for (int b = 0; b < 8; b++) v[8 * b +: 8] = pick_sign_byte();
            reg_write(r[2:0], v);
        end
        for (int i = 0; i < 8; i++)
            l[3 * i +: 3] = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                         : 3'($urandom_range(0, 4));
        reg_write(lmst_pkg::REG_SIGN_LEN, {40'd0, l});
        ig = {$urandom, $urandom};
        ig[7:0] = 8'h20;
        ig[15:8] = 8'h09;
        reg_write(lmst_pkg::REG_IGN_CHR, ig);
        reg_write(lmst_pkg::REG_IGN_CNT, 64'($urandom_range(0, 15)));
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls per token and one long hold on request.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req) begin
            i_out_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge i_clk);
            hold_req = 1'b0;
        end else begin
            if (out_taken) begin
                out_taken = 1'b0;
                stall_left = no_idle ? 0 : $urandom_range(0, 10);
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Outputs are sampled on the falling edge before the rising edge that takes them.
    always @(negedge i_clk) begin
        t_token want;
        in_seen = i_rst_n && i_in_valid && !o_in_stall;
        out_seen = 1'b0;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            out_seen = 1'b1;
            out_taken = 1'b1;
            if (pending_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token kind %0d start %0d end %0d",
                             o_token_kind, o_start_pos, o_end_pos);
            end else begin
                want = pending_tokens.pop_front();
                if (o_token_kind !== want.kind || o_start_pos !== want.first ||
                    o_end_pos !== want.past || o_pos_overflow !== want.ovf ||
                    o_last_token !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"token mismatch: expected k%0d %0d..%0d o%0d l%0d,",
                                  " got k%0d %0d..%0d o%0d l%0d"},
                                 want.kind, want.first, want.past, want.ovf,
                                 want.last, o_token_kind, o_start_pos, o_end_pos,
                                 o_pos_overflow, o_last_token);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if (in_seen || out_seen) quiet = 0;
            else quiet++;
            if (quiet >= QUIET_MAX) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed table: the first rows run on the reset configuration, where
    // every byte is part of one identifier and the token is obvious.
    // ------------------------------------------------------------------
    localparam t_token NO_TOK = '0;
    t_row rows [25] = '{
        '{ROW_TYPED, 3'd0, 64'd0, 8'h00, 1'b1,
          '{lmst_pkg::KIND_IDENT, 16'd0, 16'd1, 1'b0, 1'b1}},
        '{ROW_TYPED, 3'd0, 64'd0, 8'hFF, 1'b1,
          '{lmst_pkg::KIND_IDENT, 16'd0, 16'd1, 1'b0, 1'b1}},
        '{ROW_BYTE, 3'd0, 64'd0, 8'h41, 1'b0, NO_TOK},
        '{ROW_TYPED, 3'd0, 64'd0, 8'h42, 1'b1,
          '{lmst_pkg::KIND_IDENT, 16'd0, 16'd2, 1'b0, 1'b1}},
        // Signs: "+", "++", "+=" twice (tie), "<<=>", an over-long one,
        // an unused one, and "= " whose second byte is a separator.
        '{ROW_CFG, lmst_pkg::REG_SIGN_A, 64'h00002B2B_0000002B, 8'h00, 1'b0, NO_TOK},
        '{ROW_CFG, lmst_pkg::REG_SIGN_B, 64'h00003D2B_00003D2B, 8'h00, 1'b0, NO_TOK},
        '{ROW_CFG, lmst_pkg::REG_SIGN_C, 64'h00000061_3E3D3C3C, 8'h00, 1'b0, NO_TOK},
        '{ROW_CFG, lmst_pkg::REG_SIGN_D, 64'h0000203D_00006261, 8'h00, 1'b0, NO_TOK},
        '{ROW_CFG, lmst_pkg::REG_SIGN_LEN, 64'h42C491, 8'h00, 1'b0, NO_TOK},
        '{ROW_CFG, lmst_pkg::REG_IGN_CHR, 64'h0920, 8'h00, 1'b0, NO_TOK},
        '{ROW_CFG, lmst_pkg::REG_IGN_CNT, 64'd2, 8'h00, 1'b0, NO_TOK},
        // A lone separator leaves nothing, so only the end marker comes.
        '{ROW_TYPED, 3'd0, 64'd0, 8'h20, 1'b1,
          '{lmst_pkg::KIND_MARKER, 16'd1, 16'd1, 1'b0, 1'b1}},
        '{ROW_BYTE, 3'd0, 64'd0, 8'h61, 1'b0, NO_TOK},
        '{ROW_BYTE, 3'd0, 64'd0, 8'h62, 1'b0, NO_TOK},
        '{ROW_BYTE, 3'd0, 64'd0, 8'h2B, 1'b0, NO_TOK},
        '{ROW_BYTE, 3'd0, 64'd0, 8'h3D, 1'b0, NO_TOK},
        '{ROW_BYTE, 3'd0, 64'd0, 8'h3C, 1'b0, NO_TOK},
        '{ROW_BYTE, 3'd0, 64'd0, 8'h3C, 1'b0, NO_TOK},
        '{ROW_BYTE, 3'd0, 64'd0, 8'h3D, 1'b0, NO_TOK},
        '{ROW_BYTE, 3'd0, 64'd0, 8'h3E, 1'b0, NO_TOK},
        '{ROW_BYTE, 3'd0, 64'd0, 8'h2B, 1'b0, NO_TOK},
        '{ROW_BYTE, 3'd0, 64'd0, 8'h2B, 1'b0, NO_TOK},
        '{ROW_BYTE, 3'd0, 64'd0, 8'h09, 1'b0, NO_TOK},
        '{ROW_BYTE, 3'd0, 64'd0, 8'h3D, 1'b0, NO_TOK},
        '{ROW_BYTE, 3'd0, 64'd0, 8'h20, 1'b1, NO_TOK}
    };

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_in_valid = 1'b0; i_char_in = '0; i_end_of_source = 1'b0;
        i_out_stall = 1'b0;
        mismatches = 0; no_idle = 1'b0; hold_req = 1'b0; out_taken = 1'b0;
        stall_left = 0; in_seen = 1'b0; out_seen = 1'b0;
        for (int r = 0; r < 4; r++) sign_regs[r] = '0;
        len_reg = '0; ign_reg = '0; ign_cnt_reg = '0;
        clear_source();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            if (rows[r].what == ROW_CFG) begin
                if (r == 0 || rows[r - 1].what != ROW_CFG) drain_all();
                reg_write(rows[r].idx, rows[r].data);
            end else begin
                send_byte(rows[r].ch, rows[r].eos, rows[r].what == ROW_TYPED,
                          rows[r].tok);
            end
        end
        drain_all();

        // Random phases; the first two use the register extremes.
        for (int ph = 0; ph < 6; ph++) begin
            int sent;
            if (ph == 0) begin
                for (int r = 0; r < 4; r++) reg_write(r[2:0], '1);
                reg_write(lmst_pkg::REG_SIGN_LEN, 64'hFFFFFF);
                reg_write(lmst_pkg::REG_IGN_CHR, '1);
                reg_write(lmst_pkg::REG_IGN_CNT, 64'hF);
            end else if (ph == 1) begin
                for (int r = 0; r < 4; r++) reg_write(r[2:0], '0);
                reg_write(lmst_pkg::REG_SIGN_LEN, 64'h924924);
                reg_write(lmst_pkg::REG_IGN_CHR, 64'h0920);
                reg_write(lmst_pkg::REG_IGN_CNT, 64'd8);
            end else begin
                random_config();
            end
            no_idle = (ph == 4);
            if (ph == 3) hold_req = 1'b1;
            sent = 0;
            while (sent < 48) begin
                int  n;
                bit  noise;
                n = $urandom_range(1, 12);
                noise = ($urandom_range(0, 4) == 0);
                for (int k = 0; k < n; k++)
                    send_byte(pick_byte(noise), k == n - 1, 1'b0, NO_TOK);
                sent += n;
            end
            no_idle = 1'b0;
            drain_all();
        end

        if (mismatches == 0 && pending_tokens.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/lmst_pkg.sv
hdl/lmst_fifo.sv
hdl/lmst_front.sv
hdl/lmst_back.sv
hdl/longest_match_sign_tokenizer_unit.sv
tb/sv/testbench.sv
